// ===== design/lru_key_value_cache_unit_defines.svh =====
// assertion macros for the lru key-value cache unit
// used by lru_key_value_cache_unit.sv, no other dependencies
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LKVC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lru_kvc_pkg.sv =====
// shared types and constants for the lru key-value cache unit
// no dependencies
`timescale 1ns / 1ps

package lru_kvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int CAP_W           = 5;
    localparam int DATA_W          = 32;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } t_state;

endpackage

// ===== design/lru_key_value_cache_unit.sv =====
// the compare is registered at the input transfer, the update in ST_LOOK and the output in ST_DONE
// new items are taken in ST_IDLE or, with the output register free, in ST_DONE; this is set by the
//   read-modify-write of the value memory and rank cells, since each lookup needs the recency left by the last one
// reset: synchronous active-low; clears valid bits, ranks, entry count and state,
//   capacity returns to 16; no clearing pass, key and value storage start unwritten
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_defines.svh"

module lru_key_value_cache_unit
    import lru_kvc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CAP_W-1:0]         i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_opcode,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic                     o_evicted
);

    localparam int RANK_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [MAX_ENTRIES-1:0] ONE_VEC = MAX_ENTRIES'(1);
    localparam logic [CMP_W-1:0]       MAX_CMP = CMP_W'(MAX_ENTRIES);

    // control
    t_state               r_state, n_state;
    logic                 r_out_valid;
    logic [CAP_W-1:0]     r_cap;
    logic [CNT_W-1:0]     r_count;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [RANK_W-1:0]    r_rank [MAX_ENTRIES];

    // item and tag cells
    t_opcode              r_op;
    logic [DATA_W-1:0]    r_item_key;
    logic [DATA_W-1:0]    r_item_value;
    logic [DATA_W-1:0]    r_tag [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_match;

    // value memory
    logic [DATA_W-1:0]    r_value_mem [MAX_ENTRIES];
    logic [DATA_W-1:0]    r_rd_data;

    // result of the update step
    logic                 r_res_hit;
    logic                 r_res_get;
    logic                 r_res_ev;
    logic                 r_hit_q;
    logic [DATA_W-1:0]    r_rd_value_q;
    logic                 r_ev_q;

    logic                 in_xfer;
    logic                 out_free;
    logic                 load_out;
    logic                 hit;
    logic                 need_evict;
    logic [RANK_W-1:0]    hit_rank;
    logic [RANK_W-1:0]    lru_rank;
    logic [CMP_W-1:0]     eff_cap;
    logic [MAX_ENTRIES-1:0] lru_oh;
    logic [MAX_ENTRIES-1:0] valid_after;
    logic [MAX_ENTRIES-1:0] free_oh;
    logic [MAX_ENTRIES-1:0] sel_oh;
    logic [RANK_W-1:0]    sel_idx;
    logic                 mem_we;
    logic                 mem_re;

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // next item may start while the result moves to the output register
                if (out_free) begin
                    load_out   = 1'b1;
                    o_in_ready = 1'b1;
                    n_state    = i_in_valid ? ST_LOOK : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign in_xfer  = i_in_valid && o_in_ready;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_comb begin
        eff_cap = CMP_W'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end
        if (eff_cap > MAX_CMP) begin
            eff_cap = MAX_CMP;
        end
    end

    // capture the item and compare its key against every tag cell
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op         <= t_opcode'(i_opcode);
            r_item_key   <= i_key;
            r_item_value <= i_value;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_match[i] <= r_valid[i] && (r_tag[i] == i_key);
            end
        end
    end

    // update step logic
    assign hit      = |r_match;
    assign lru_rank = RANK_W'(r_count - CNT_W'(1));

    always_comb begin
        hit_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_match[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
            lru_oh[i] = r_valid[i] && (r_rank[i] == lru_rank);
        end
        need_evict  = (r_op == OP_PUT) && !hit && (CMP_W'(r_count) >= eff_cap);
        valid_after = need_evict ? (r_valid & ~lru_oh) : r_valid;
        // lowest free slot after a possible eviction
        free_oh     = ~valid_after & (valid_after + ONE_VEC);
        sel_oh      = hit ? r_match : free_oh;
        sel_idx     = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (sel_oh[i]) begin
                sel_idx = sel_idx | RANK_W'(i);
            end
        end
    end

    assign mem_we = (r_state == ST_LOOK) && (r_op == OP_PUT);
    assign mem_re = (r_state == ST_LOOK) && (r_op == OP_GET) && hit;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_value_mem[sel_idx] <= r_item_value;
        end
        if (mem_re) begin
            r_rd_data <= r_value_mem[sel_idx];
        end
    end

    // valid bits, recency ranks and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (r_state == ST_LOOK) begin
            if (hit) begin
                // entries more recent than the hit age by one
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (r_match[i]) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
            end else if (r_op == OP_PUT) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (free_oh[i]) begin
                        r_rank[i] <= '0;
                    end else if (valid_after[i]) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
                r_valid <= valid_after | free_oh;
                if (!need_evict) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_LOOK) && (r_op == OP_PUT) && !hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (free_oh[i]) begin
                    r_tag[i] <= r_item_key;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK) begin
            r_res_hit <= hit;
            r_res_get <= (r_op == OP_GET);
            r_res_ev  <= need_evict;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_hit_q      <= r_res_hit;
            r_rd_value_q <= (r_res_get && r_res_hit) ? r_rd_data : MISS_VALUE;
            r_ev_q       <= r_res_ev;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit_q;
    assign o_read_value = r_rd_value_q;
    assign o_evicted    = r_ev_q;

    `LKVC_ASSERT_SAME(a_count_matches_valid, i_clk, i_rst_n, 1'b1, r_count == CNT_W'($countones(r_valid)), "entry count differs from number of valid entries")
    `LKVC_ASSERT_SAME(a_single_match, i_clk, i_rst_n, r_state == ST_LOOK, $onehot0(r_match), "key found in more than one entry")
    `LKVC_ASSERT_NEXT(a_xfer_to_look, i_clk, i_rst_n, in_xfer, r_state == ST_LOOK, "input transfer did not start an update")
    `LKVC_ASSERT_SAME(a_evict_only_on_put_miss, i_clk, i_rst_n, need_evict, !hit && (r_count != '0), "eviction without a put miss on a non-empty store")

endmodule
